[src/mwosc_pkg.sv]
// Shared widths, codes, configuration and control types, sine table function for the oscillator.
package mwosc_pkg;

  localparam int RATE_W      = 25;
  localparam int INV_W       = 37;
  localparam int INV_LO_W    = 19;
  localparam int INV_HI_W    = INV_W - INV_LO_W;
  localparam int MAG_W       = RATE_W + INV_W;
  localparam int INC_POINT   = 48;
  localparam int PHASE_IN_W  = 32;
  localparam int PHASE_MAX_W = 48;
  localparam int LEVEL_W     = 16;
  localparam int SAMPLE_W    = 16;
  localparam int LFSR_W      = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 37;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 32'h0000_ACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

  typedef enum logic [2:0] {
    SHAPE_SINE      = 3'd0,
    SHAPE_SQUARE    = 3'd1,
    SHAPE_SAW_UP    = 3'd2,
    SHAPE_SAW_DOWN  = 3'd3,
    SHAPE_TRIANGLE  = 3'd4,
    SHAPE_IMPULSE   = 3'd5,
    SHAPE_NOISE     = 3'd6,
    SHAPE_DC        = 3'd7
  } shape_t;

  typedef enum logic [1:0] {
    MODE_CONST    = 2'd0,
    MODE_RATE_IN  = 2'd1,
    MODE_PHASE_IN = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVE_SHAPE      = 3'd0,
    CFG_DRIVE_MODE      = 3'd1,
    CFG_PEAK_LEVEL      = 3'd2,
    CFG_CONST_RATE_HZ   = 3'd3,
    CFG_INV_SAMPLE_RATE = 3'd4,
    CFG_START_PHASE     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]                wave_shape;
    logic [1:0]                drive_mode;
    logic signed [LEVEL_W-1:0] peak_level;
    logic signed [RATE_W-1:0]  const_rate_hz;
    logic [INV_W-1:0]          inv_sample_rate;
    logic [PHASE_IN_W-1:0]     start_phase;
  } mwosc_cfg_t;

  localparam mwosc_cfg_t CFG_RESET = '{
    wave_shape:      SHAPE_SINE,
    drive_mode:      MODE_CONST,
    peak_level:      16'sd32767,
    const_rate_hz:   25'sd256,
    inv_sample_rate: 37'd23900098,
    start_phase:     32'd0
  };

  typedef struct packed {
    logic restart;
    logic block_last;
    logic phase_mode;
    logic rate_neg;
    logic inc_carry;
  } mwosc_ctrl_t;

  localparam int CTRL_W = $bits(mwosc_ctrl_t);

  function automatic logic [SAMPLE_W-1:0] sine_entry(input int unsigned k,
                                                     input int unsigned qbits);
    logic [63:0] q;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] e;
    q  = 64'(k) << (28 - qbits);
    x  = (q * HALF_PI_Q30) >> 28;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    e  = (s * 64'd32768 + (64'd1 << 29)) >> 30;
    if (e > 64'd32768) begin
      e = 64'd32768;
    end
    return e[SAMPLE_W-1:0];
  endfunction

endpackage

[src/mwosc_in_if.sv]
// Input sample-request channel: valid/ready with rate, phase, restart and block marker.
interface mwosc_in_if import mwosc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [RATE_W-1:0] rate_in;
  logic [PHASE_IN_W-1:0]    phase_in;
  logic                     restart;
  logic                     block_last;

  modport source(output valid, rate_in, phase_in, restart, block_last, input ready);
  modport sink(input valid, rate_in, phase_in, restart, block_last, output ready);
endinterface

[src/mwosc_out_if.sv]
// Output sample channel: valid/ready with the saturated sample and block marker.
interface mwosc_out_if import mwosc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       end_of_block;

  modport source(output valid, sample, end_of_block, input ready);
  modport sink(input valid, sample, end_of_block, output ready);
endinterface

[src/mwosc_front.sv]
// Front end: accepts beats, resolves drive mode, aligns phase, computes the phase increment.
module mwosc_front import mwosc_pkg::*; #(
  parameter int PHASE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mwosc_in_if.sink              in_ch,
  input  mwosc_cfg_t            cfg,
  input  logic                  q_full,
  output logic                  push,
  output mwosc_ctrl_t           push_ctrl,
  output logic [PHASE_BITS-1:0] push_phase,
  output logic [PHASE_BITS-1:0] push_inc
);

  localparam int LO_W = RATE_W + INV_LO_W;
  localparam int HI_W = RATE_W + INV_HI_W;

  logic                     adv;
  logic                     accept;
  logic signed [RATE_W-1:0] rate_sel;
  logic [RATE_W-1:0]        rate_mag;
  logic [PHASE_MAX_W-1:0]   ph_wide;
  logic [MAG_W-1:0]         full_mag;
  mwosc_ctrl_t              in_ctrl;

  logic                  s1_valid_r, s1_valid_nxt;
  mwosc_ctrl_t           s1_ctrl_r, s1_ctrl_nxt;
  logic [RATE_W-1:0]     s1_mag_r, s1_mag_nxt;
  logic [PHASE_BITS-1:0] s1_phase_r, s1_phase_nxt;

  logic                  s2_valid_r, s2_valid_nxt;
  mwosc_ctrl_t           s2_ctrl_r, s2_ctrl_nxt;
  logic [LO_W-1:0]       s2_lo_r, s2_lo_nxt;
  logic [HI_W-1:0]       s2_hi_r, s2_hi_nxt;
  logic [PHASE_BITS-1:0] s2_phase_r, s2_phase_nxt;

  assign adv         = !(s2_valid_r && q_full);
  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;

  always_comb begin
    rate_sel = (cfg.drive_mode == MODE_RATE_IN) ? in_ch.rate_in : cfg.const_rate_hz;
    rate_mag = rate_sel[RATE_W-1] ? RATE_W'(~rate_sel + 1'b1) : rate_sel;
    ph_wide  = {in_ch.phase_in, (PHASE_MAX_W - PHASE_IN_W)'(0)};
    in_ctrl.restart    = in_ch.restart;
    in_ctrl.block_last = in_ch.block_last;
    in_ctrl.phase_mode = (cfg.drive_mode == MODE_PHASE_IN);
    in_ctrl.rate_neg   = rate_sel[RATE_W-1];
    in_ctrl.inc_carry  = 1'b0;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_ctrl_nxt  = s1_ctrl_r;
    s1_mag_nxt   = s1_mag_r;
    s1_phase_nxt = s1_phase_r;
    s2_valid_nxt = s2_valid_r;
    s2_ctrl_nxt  = s2_ctrl_r;
    s2_lo_nxt    = s2_lo_r;
    s2_hi_nxt    = s2_hi_r;
    s2_phase_nxt = s2_phase_r;
    if (adv) begin
      s1_valid_nxt = accept;
      s1_ctrl_nxt  = in_ctrl;
      s1_mag_nxt   = rate_mag;
      s1_phase_nxt = ph_wide[PHASE_MAX_W-1 -: PHASE_BITS];
      s2_valid_nxt = s1_valid_r;
      s2_ctrl_nxt  = s1_ctrl_r;
      s2_lo_nxt    = LO_W'(s1_mag_r) * LO_W'(cfg.inv_sample_rate[INV_LO_W-1:0]);
      s2_hi_nxt    = HI_W'(s1_mag_r) * HI_W'(cfg.inv_sample_rate[INV_W-1:INV_LO_W]);
      s2_phase_nxt = s1_phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctrl_r  <= s1_ctrl_nxt;
    s1_mag_r   <= s1_mag_nxt;
    s1_phase_r <= s1_phase_nxt;
    s2_ctrl_r  <= s2_ctrl_nxt;
    s2_lo_r    <= s2_lo_nxt;
    s2_hi_r    <= s2_hi_nxt;
    s2_phase_r <= s2_phase_nxt;
  end

  always_comb begin
    full_mag   = (MAG_W'(s2_hi_r) << INV_LO_W) + MAG_W'(s2_lo_r);
    push       = s2_valid_r && !q_full;
    push_ctrl  = s2_ctrl_r;
    push_ctrl.inc_carry = |full_mag[MAG_W-1:INC_POINT];
    push_phase = s2_phase_r;
    push_inc   = full_mag[INC_POINT-1 -: PHASE_BITS];
  end

endmodule

[src/mwosc_queue.sv]
// Small register queue decoupling the front end from the waveform back end.
module mwosc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue underflow");

endmodule

[src/mwosc_back.sv]
// Back end: phase accumulator, noise LFSR, sine table, level multiply, saturate, output register.
module mwosc_back import mwosc_pkg::*; #(
  parameter int SINE_TABLE_ADDR_BITS = 10,
  parameter int PHASE_BITS           = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mwosc_cfg_t            cfg,
  input  logic                  q_empty,
  input  mwosc_ctrl_t           head_ctrl,
  input  logic [PHASE_BITS-1:0] head_phase,
  input  logic [PHASE_BITS-1:0] head_inc,
  output logic                  pop,
  mwosc_out_if.source           out_ch
);

  localparam int AB     = SINE_TABLE_ADDR_BITS;
  localparam int QBITS  = AB - 2;
  localparam int QN     = 1 << QBITS;
  localparam int OP_W   = PHASE_IN_W + 1;
  localparam int PROD_W = LEVEL_W + OP_W;
  localparam int V_W    = LEVEL_W + 3;

  typedef logic [SAMPLE_W-1:0] rom_t [QN+1];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i <= QN; i++) begin
      r[i] = sine_entry(i, QBITS);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic                          adv;
  logic [PHASE_MAX_W-1:0]        start_wide;
  logic [PHASE_BITS-1:0]         start_al;
  logic [PHASE_BITS-1:0]         acc_cur;
  logic                          due_cur;
  logic [PHASE_BITS-1:0]         cur;
  logic [PHASE_BITS+31:0]        cur_wide;
  logic [PHASE_IN_W-1:0]         p32;
  logic                          fire;
  logic [AB-1:0]                 rom_addr;
  logic [QBITS:0]                rom_idx;
  logic [PHASE_BITS:0]           acc_sum;
  logic signed [OP_W-1:0]        mul_op;
  logic signed [V_W-1:0]         lvl;
  logic signed [PROD_W-1:0]      rnd;
  logic signed [V_W-1:0]         v;

  logic [PHASE_BITS-1:0]         acc_r, acc_nxt;
  logic                          due_r, due_nxt;
  logic [LFSR_W-1:0]             lfsr_r, lfsr_nxt;

  logic                          b_valid_r, b_valid_nxt;
  logic [SAMPLE_W-1:0]           b_rom_r, b_rom_nxt;
  logic                          b_neg_r, b_neg_nxt;
  logic [PHASE_IN_W-1:0]         b_p32_r, b_p32_nxt;
  logic                          b_fire_r, b_fire_nxt;
  logic [SAMPLE_W-1:0]           b_noise_r, b_noise_nxt;
  logic                          b_last_r, b_last_nxt;

  logic                          c_valid_r, c_valid_nxt;
  logic signed [PROD_W-1:0]      c_prod_r, c_prod_nxt;
  logic                          c_half_r, c_half_nxt;
  logic                          c_fire_r, c_fire_nxt;
  logic                          c_last_r, c_last_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0]    out_sample_r, out_sample_nxt;
  logic                          out_last_r, out_last_nxt;

  assign adv = !out_valid_r || out_ch.ready;
  assign pop = !q_empty && adv;

  always_comb begin
    start_wide = {cfg.start_phase, (PHASE_MAX_W - PHASE_IN_W)'(0)};
    start_al   = start_wide[PHASE_MAX_W-1 -: PHASE_BITS];
    acc_cur    = head_ctrl.restart ? start_al : acc_r;
    due_cur    = head_ctrl.restart ? (cfg.start_phase == '0) : due_r;
    cur        = head_ctrl.phase_mode ? head_phase : acc_cur;
    fire       = due_cur || (head_ctrl.phase_mode && (head_phase < acc_cur));
    cur_wide   = {cur, 32'h0};
    p32        = cur_wide[PHASE_BITS+31 -: PHASE_IN_W];
    rom_addr   = p32[PHASE_IN_W-1 -: AB];
    rom_idx    = rom_addr[QBITS] ? ((QBITS+1)'(QN) - {1'b0, rom_addr[QBITS-1:0]})
                                 : {1'b0, rom_addr[QBITS-1:0]};
    acc_sum    = {1'b0, acc_cur} + {1'b0, head_inc};
  end

  always_comb begin
    acc_nxt  = acc_r;
    due_nxt  = due_r;
    lfsr_nxt = lfsr_r;
    if (pop) begin
      lfsr_nxt = lfsr_r[0] ? ((lfsr_r >> 1) ^ LFSR_TAPS) : (lfsr_r >> 1);
      priority if (head_ctrl.phase_mode) begin
        acc_nxt = head_phase;
        due_nxt = 1'b0;
      end else if (head_ctrl.rate_neg) begin
        acc_nxt = acc_cur - head_inc;
        due_nxt = 1'b0;
      end else begin
        acc_nxt = acc_sum[PHASE_BITS-1:0];
        due_nxt = acc_sum[PHASE_BITS] || head_ctrl.inc_carry;
      end
    end
  end

  always_comb begin
    unique case (cfg.wave_shape)
      SHAPE_SINE:     mul_op = b_neg_r ? -OP_W'($signed({1'b0, b_rom_r}))
                                       : OP_W'($signed({1'b0, b_rom_r}));
      SHAPE_SAW_UP,
      SHAPE_SAW_DOWN: mul_op = $signed({1'b0, b_p32_r});
      SHAPE_TRIANGLE: mul_op = $signed({2'b00, b_p32_r[PHASE_IN_W-2:0]});
      SHAPE_NOISE:    mul_op = OP_W'($signed({~b_noise_r[SAMPLE_W-1],
                                               b_noise_r[SAMPLE_W-2:0]}));
      default:        mul_op = '0;
    endcase
  end

  always_comb begin
    lvl = V_W'(cfg.peak_level);
    rnd = c_prod_r + PROD_W'(16384);
    unique case (cfg.wave_shape)
      SHAPE_SINE:     v = $signed(rnd[V_W+14:15]);
      SHAPE_SQUARE:   v = c_half_r ? -lvl : lvl;
      SHAPE_SAW_UP:   v = V_W'($signed(c_prod_r[PROD_W-1:31])) - lvl;
      SHAPE_SAW_DOWN: v = lvl - V_W'($signed(c_prod_r[PROD_W-1:31]));
      SHAPE_TRIANGLE: v = c_half_r ? (lvl - $signed(c_prod_r[V_W+29:30]))
                                   : ($signed(c_prod_r[V_W+29:30]) - lvl);
      SHAPE_IMPULSE:  v = c_fire_r ? lvl : '0;
      SHAPE_NOISE:    v = $signed(c_prod_r[V_W+14:15]);
      default:        v = lvl;
    endcase
  end

  always_comb begin
    b_valid_nxt    = b_valid_r;
    b_rom_nxt      = b_rom_r;
    b_neg_nxt      = b_neg_r;
    b_p32_nxt      = b_p32_r;
    b_fire_nxt     = b_fire_r;
    b_noise_nxt    = b_noise_r;
    b_last_nxt     = b_last_r;
    c_valid_nxt    = c_valid_r;
    c_prod_nxt     = c_prod_r;
    c_half_nxt     = c_half_r;
    c_fire_nxt     = c_fire_r;
    c_last_nxt     = c_last_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    if (adv) begin
      b_valid_nxt    = pop;
      b_rom_nxt      = SINE_ROM[rom_idx];
      b_neg_nxt      = rom_addr[AB-1];
      b_p32_nxt      = p32;
      b_fire_nxt     = fire;
      b_noise_nxt    = lfsr_r[SAMPLE_W-1:0];
      b_last_nxt     = head_ctrl.block_last;
      c_valid_nxt    = b_valid_r;
      c_prod_nxt     = PROD_W'(cfg.peak_level) * PROD_W'(mul_op);
      c_half_nxt     = b_p32_r[PHASE_IN_W-1];
      c_fire_nxt     = b_fire_r;
      c_last_nxt     = b_last_r;
      out_valid_nxt  = c_valid_r;
      out_last_nxt   = c_last_r;
      priority if (v > V_W'(SAMPLE_MAX)) begin
        out_sample_nxt = SAMPLE_MAX;
      end else if (v < V_W'(SAMPLE_MIN)) begin
        out_sample_nxt = SAMPLE_MIN;
      end else begin
        out_sample_nxt = v[SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      due_r       <= 1'b1;
      lfsr_r      <= LFSR_SEED;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      due_r       <= due_nxt;
      lfsr_r      <= lfsr_nxt;
      b_valid_r   <= b_valid_nxt;
      c_valid_r   <= c_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_rom_r      <= b_rom_nxt;
    b_neg_r      <= b_neg_nxt;
    b_p32_r      <= b_p32_nxt;
    b_fire_r     <= b_fire_nxt;
    b_noise_r    <= b_noise_nxt;
    b_last_r     <= b_last_nxt;
    c_prod_r     <= c_prod_nxt;
    c_half_r     <= c_half_nxt;
    c_fire_r     <= c_fire_nxt;
    c_last_r     <= c_last_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample       = out_sample_r;
  assign out_ch.end_of_block = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n) lfsr_r != '0)
    else $error("noise generator reached zero");
  assert property (@(posedge clk) disable iff (!rst_n)
    pop && head_ctrl.phase_mode |=> (acc_r == $past(head_phase)) && !due_r)
    else $error("phase input not loaded into accumulator");
  assert property (@(posedge clk) disable iff (!rst_n)
    pop && !head_ctrl.phase_mode && head_ctrl.rate_neg |=> !due_r)
    else $error("impulse armed by a backward step");

endmodule

[src/multi_waveform_oscillator.sv]
// Top level of the multi-waveform oscillator: configuration registers, front end, queue, back end.
//
// One sample request in, one signed 16-bit sample out, sustained at one beat per clock while
// the output is ready. A request passes the front end, where the 25x37-bit rate times inverse
// sample rate product is formed as two registered partial products, then the queue and the
// back end (phase select and registered sine table read, level multiply, saturate into the
// output register). The rate is set by the phase accumulator, a single add or subtract in
// the back end's first stage. The four-entry queue lets requests keep arriving while the
// output is stalled, until the queue is full. The sine table holds a quarter wave of
// 2^(SINE_TABLE_ADDR_BITS-2)+1 entries built at elaboration; no clearing pass runs after reset.
// Write configuration only while no sample is in flight.
module multi_waveform_oscillator import mwosc_pkg::*; #(
  parameter int SINE_TABLE_ADDR_BITS = 10,
  parameter int PHASE_BITS           = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mwosc_in_if.sink              in_ch,
  mwosc_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int Q_W = CTRL_W + 2 * PHASE_BITS;

  mwosc_cfg_t            cfg_r, cfg_nxt;
  logic                  push;
  mwosc_ctrl_t           push_ctrl;
  logic [PHASE_BITS-1:0] push_phase;
  logic [PHASE_BITS-1:0] push_inc;
  logic                  q_full;
  logic                  q_empty;
  logic                  pop;
  logic [Q_W-1:0]        q_rdata;
  mwosc_ctrl_t           head_ctrl;
  logic [PHASE_BITS-1:0] head_phase;
  logic [PHASE_BITS-1:0] head_inc;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WAVE_SHAPE:      cfg_nxt.wave_shape      = cfg_wdata[2:0];
        CFG_DRIVE_MODE:      cfg_nxt.drive_mode      = cfg_wdata[1:0];
        CFG_PEAK_LEVEL:      cfg_nxt.peak_level      = cfg_wdata[LEVEL_W-1:0];
        CFG_CONST_RATE_HZ:   cfg_nxt.const_rate_hz   = cfg_wdata[RATE_W-1:0];
        CFG_INV_SAMPLE_RATE: cfg_nxt.inv_sample_rate = cfg_wdata[INV_W-1:0];
        CFG_START_PHASE:     cfg_nxt.start_phase     = cfg_wdata[PHASE_IN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mwosc_front #(
    .PHASE_BITS(PHASE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .q_full     (q_full),
    .push       (push),
    .push_ctrl  (push_ctrl),
    .push_phase (push_phase),
    .push_inc   (push_inc)
  );

  mwosc_queue #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({push_ctrl, push_phase, push_inc}),
    .full  (q_full),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign {head_ctrl, head_phase, head_inc} = q_rdata;

  mwosc_back #(
    .SINE_TABLE_ADDR_BITS(SINE_TABLE_ADDR_BITS),
    .PHASE_BITS(PHASE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .head_ctrl  (head_ctrl),
    .head_phase (head_phase),
    .head_inc   (head_inc),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

[tb/sv/multi_waveform_oscillator_tb.sv]
// Self-checking testbench for the multi-waveform oscillator: directed table, random settings.
module multi_waveform_oscillator_tb;
  import mwosc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROM_BITS = 10;
  localparam int ROM_DEPTH = 1 << ROM_BITS;
  localparam int QUARTER_BITS = ROM_BITS - 2;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 150;
  localparam int IDLE_PCT = 29;
  localparam int N_SETTINGS = 16;
  localparam int BEATS_PER_SETTING = 90;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [31:0] NOISE_SEED = 32'h0000_ACE1;
  localparam logic [31:0] NOISE_TAPS = 32'h8020_0003;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] TAYLOR_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  localparam logic signed [15:0] LVL_MAX = 16'sh7fff;
  localparam logic signed [15:0] LVL_MIN = 16'sh8000;
  localparam logic signed [24:0] RATE_MAX = 25'sh0ff_ffff;
  localparam logic signed [24:0] RATE_MIN = 25'sh100_0000;
  localparam logic [36:0] INV_MAX = 37'h10_0000_0000;
  localparam logic [36:0] INV_RESET = 37'd23900098;

  typedef struct packed {
    logic signed [RATE_W-1:0] rate;
    logic [31:0]              phase;
    logic                     restart;
    logic                     last;
  } osc_req_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               eob;
  } osc_out_t;

  typedef struct packed {
    shape_t                   shape;
    logic [1:0]               mode;
    logic signed [15:0]       level;
    logic signed [RATE_W-1:0] rate;
    logic [31:0]              phase;
    logic                     restart;
    logic                     last;
    logic                     pinned;
    logic signed [15:0]       pin_sample;
  } dir_row_t;

  localparam int N_DIR = 25;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{SHAPE_SINE,     MODE_CONST,    LVL_MAX, 25'sd0,   32'h0000_0000, 1'b0, 1'b0, 1'b1, 16'sd0},
    '{SHAPE_SINE,     MODE_CONST,    LVL_MAX, RATE_MAX, 32'hffff_ffff, 1'b1, 1'b1, 1'b0, 16'sd0},
    '{SHAPE_DC,       MODE_CONST,    LVL_MAX, 25'sd0,   32'h0000_0000, 1'b0, 1'b0, 1'b1, LVL_MAX},
    '{SHAPE_DC,       MODE_CONST,    LVL_MIN, 25'sd0,   32'h0000_0000, 1'b0, 1'b1, 1'b1, LVL_MIN},
    '{SHAPE_SQUARE,   MODE_PHASE_IN, LVL_MIN, 25'sd0,   32'h0000_0000, 1'b0, 1'b0, 1'b1, LVL_MIN},
    '{SHAPE_SQUARE,   MODE_PHASE_IN, LVL_MAX, 25'sd0,   32'h8000_0000, 1'b0, 1'b0, 1'b1, -16'sd32767},
    '{SHAPE_SQUARE,   MODE_PHASE_IN, LVL_MAX, 25'sd0,   32'hffff_ffff, 1'b0, 1'b0, 1'b1, -16'sd32767},
    '{SHAPE_SAW_UP,   MODE_PHASE_IN, LVL_MAX, 25'sd0,   32'h0000_0000, 1'b0, 1'b0, 1'b1, -16'sd32767},
    '{SHAPE_SAW_UP,   MODE_PHASE_IN, LVL_MAX, 25'sd0,   32'hffff_ffff, 1'b0, 1'b0, 1'b0, 16'sd0},
    '{SHAPE_SAW_DOWN, MODE_PHASE_IN, LVL_MIN, 25'sd0,   32'h0000_0000, 1'b0, 1'b0, 1'b1, LVL_MIN},
    '{SHAPE_TRIANGLE, MODE_PHASE_IN, LVL_MAX, 25'sd0,   32'h0000_0000, 1'b0, 1'b0, 1'b1, -16'sd32767},
    '{SHAPE_TRIANGLE, MODE_PHASE_IN, LVL_MAX, 25'sd0,   32'h8000_0000, 1'b0, 1'b0, 1'b1, LVL_MAX},
    '{SHAPE_TRIANGLE, MODE_PHASE_IN, LVL_MIN, 25'sd0,   32'hc000_0000, 1'b0, 1'b0, 1'b0, 16'sd0},
    '{SHAPE_SINE,     MODE_PHASE_IN, LVL_MAX, 25'sd0,   32'h4000_0000, 1'b0, 1'b0, 1'b0, 16'sd0},
    '{SHAPE_SINE,     MODE_PHASE_IN, LVL_MIN, 25'sd0,   32'hc000_0000, 1'b0, 1'b0, 1'b0, 16'sd0},
    '{SHAPE_IMPULSE,  MODE_PHASE_IN, LVL_MAX, 25'sd0,   32'h1000_0000, 1'b0, 1'b0, 1'b0, 16'sd0},
    '{SHAPE_IMPULSE,  MODE_PHASE_IN, LVL_MAX, 25'sd0,   32'h2000_0000, 1'b0, 1'b0, 1'b1, 16'sd0},
    '{SHAPE_IMPULSE,  MODE_RATE_IN,  LVL_MAX, RATE_MAX, 32'h0000_0000, 1'b1, 1'b0, 1'b1, LVL_MAX},
    '{SHAPE_IMPULSE,  MODE_RATE_IN,  LVL_MAX, RATE_MAX, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'sd0},
    '{SHAPE_IMPULSE,  MODE_RATE_IN,  LVL_MAX, RATE_MIN, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 16'sd0},
    '{SHAPE_NOISE,    MODE_CONST,    LVL_MAX, 25'sd0,   32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'sd0},
    '{SHAPE_NOISE,    MODE_CONST,    LVL_MIN, 25'sd0,   32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'sd0},
    '{SHAPE_SAW_DOWN, MODE_UNUSED,   LVL_MAX, RATE_MIN, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'sd0},
    '{SHAPE_DC,       MODE_RATE_IN,  16'sd0,  -25'sd1,  32'h0000_0000, 1'b0, 1'b0, 1'b1, 16'sd0},
    '{SHAPE_SINE,     MODE_RATE_IN,  LVL_MAX, RATE_MIN, 32'hffff_ffff, 1'b1, 1'b1, 1'b0, 16'sd0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mwosc_in_if in_if ();
  mwosc_out_if out_if ();

  multi_waveform_oscillator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // oscillator model state and register copies
  int sine_rom [ROM_DEPTH];
  shape_t cur_shape;
  logic [1:0] cur_mode;
  logic signed [15:0] cur_level;
  logic signed [RATE_W-1:0] cur_const_rate;
  logic [36:0] cur_inv;
  logic [31:0] cur_start;
  logic [31:0] acc;
  logic imp_due;
  logic [31:0] lfsr;

  osc_out_t expected_q[$];
  int unsigned errors = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned settings_used = 0;

  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit hold_ask = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  function automatic logic [63:0] quarter_sine_q30(logic [63:0] q);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x = (q * PI_HALF_Q30) >> 28;
    x2 = (x * x) >> 30;
    t = ONE_Q30;
    for (int n = 0; n < 5; n++) begin
      t = ONE_Q30 - ((x2 * t) >> 30) / TAYLOR_DIV[n];
    end
    return (x * t) >> 30;
  endfunction

  function automatic void reset_model();
    logic [63:0] q;
    logic [63:0] e;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      q = 64'(i & ((1 << QUARTER_BITS) - 1)) << (28 - QUARTER_BITS);
      if (((i >> QUARTER_BITS) & 1) != 0) begin
        q = (64'd1 << 28) - q;
      end
      e = (quarter_sine_q30(q) * 64'd32768 + (64'd1 << 29)) >> 30;
      if (e > 64'd32768) begin
        e = 64'd32768;
      end
      sine_rom[i] = (((i >> QUARTER_BITS) & 2) != 0) ? -int'(e) : int'(e);
    end
    cur_shape = SHAPE_SINE;
    cur_mode = MODE_CONST;
    cur_level = LVL_MAX;
    cur_const_rate = 25'sd256;
    cur_inv = INV_RESET;
    cur_start = 32'd0;
    acc = cur_start;
    imp_due = 1'b1;
    lfsr = NOISE_SEED;
  endfunction

  function automatic osc_out_t next_sample(osc_req_t r);
    osc_out_t res;
    logic [1:0] m;
    logic [31:0] ph;
    logic fire;
    longint lv;
    longint pl;
    longint v;
    longint rv;
    logic [63:0] rmag;
    logic [63:0] inc;
    logic [63:0] sum;
    m = (cur_mode == MODE_UNUSED) ? MODE_CONST : cur_mode;
    lv = longint'(cur_level);
    if (r.restart) begin
      acc = cur_start;
      imp_due = (cur_start == 32'd0);
    end
    ph = (m == MODE_PHASE_IN) ? r.phase : acc;
    fire = imp_due || (m == MODE_PHASE_IN && r.phase < acc);
    pl = longint'({32'd0, ph});
    case (cur_shape)
      SHAPE_SINE:     v = (longint'(sine_rom[ph[31 -: ROM_BITS]]) * lv + 16384) >>> 15;
      SHAPE_SQUARE:   v = ph[31] ? -lv : lv;
      SHAPE_SAW_UP:   v = -lv + ((lv * pl) >>> 31);
      SHAPE_SAW_DOWN: v = lv - ((lv * pl) >>> 31);
      SHAPE_TRIANGLE: begin
        if (!ph[31]) begin
          v = ((lv * pl) >>> 30) - lv;
        end else begin
          v = lv - ((lv * (pl - 64'sd2147483648)) >>> 30);
        end
      end
      SHAPE_IMPULSE:  v = fire ? lv : 0;
      SHAPE_NOISE:    v = ((longint'({48'd0, lfsr[15:0]}) - 32768) * lv) >>> 15;
      default:        v = lv;
    endcase
    lfsr = lfsr[0] ? ((lfsr >> 1) ^ NOISE_TAPS) : (lfsr >> 1);
    if (m == MODE_PHASE_IN) begin
      acc = r.phase;
      imp_due = 1'b0;
    end else begin
      rv = (m == MODE_CONST) ? longint'(cur_const_rate) : longint'(r.rate);
      rmag = (rv < 0) ? 64'(-rv) : 64'(rv);
      inc = (rmag * {27'd0, cur_inv}) >> 16;
      if (rv < 0) begin
        acc = acc - inc[31:0];
        imp_due = 1'b0;
      end else begin
        sum = {32'd0, acc} + inc;
        imp_due = (sum > 64'hffff_ffff);
        acc = sum[31:0];
      end
    end
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    res.sample = v[15:0];
    res.eob = r.last;
    return res;
  endfunction

  task automatic reg_write(cfg_idx_t idx, logic [36:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_WAVE_SHAPE:      cur_shape = shape_t'(data[2:0]);
      CFG_DRIVE_MODE:      cur_mode = data[1:0];
      CFG_PEAK_LEVEL:      cur_level = data[15:0];
      CFG_CONST_RATE_HZ:   cur_const_rate = data[RATE_W-1:0];
      CFG_INV_SAMPLE_RATE: cur_inv = data;
      CFG_START_PHASE:     cur_start = data[31:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid and wait until every expected sample is back
  task automatic settle();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_beat(osc_req_t r, logic pinned, logic signed [15:0] pin_sample);
    osc_out_t e;
    while (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.rate_in <= r.rate;
    in_if.phase_in <= r.phase;
    in_if.restart <= r.restart;
    in_if.block_last <= r.last;
    do @(posedge clk); while (!in_if.ready);
    e = next_sample(r);
    if (pinned) begin
      e.sample = pin_sample;
    end
    expected_q.push_back(e);
    beats_sent++;
  endtask

  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= rx_calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_out
    osc_out_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat, sample %0d end_of_block %0b", $time,
                 out_if.sample, out_if.end_of_block);
        errors++;
      end else begin
        want = expected_q.pop_front();
        beats_checked++;
        if (out_if.sample !== want.sample) begin
          $display("%0t: sample mismatch, expected %0d got %0d", $time,
                   want.sample, out_if.sample);
          errors++;
        end
        if (out_if.end_of_block !== want.eob) begin
          $display("%0t: end_of_block mismatch, expected %0b got %0b", $time,
                   want.eob, out_if.end_of_block);
          errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("multi_waveform_oscillator_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    osc_req_t req;
    dir_row_t row;
    logic [1:0] mode_sel;
    logic signed [15:0] level_sel;
    logic signed [RATE_W-1:0] rate_sel;
    logic [36:0] inv_sel;
    logic [31:0] start_sel;
    logic [31:0] ramp;
    logic [31:0] ramp_step;

    in_if.valid <= 1'b0;
    in_if.rate_in <= '0;
    in_if.phase_in <= '0;
    in_if.restart <= 1'b0;
    in_if.block_last <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_WAVE_SHAPE;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    reset_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      row = DIR_ROWS[i];
      if (row.shape != cur_shape || row.mode != cur_mode || row.level != cur_level) begin
        settle();
        if (row.shape != cur_shape) reg_write(CFG_WAVE_SHAPE, 37'(row.shape));
        if (row.mode != cur_mode) reg_write(CFG_DRIVE_MODE, 37'(row.mode));
        if (row.level != cur_level) reg_write(CFG_PEAK_LEVEL, 37'(row.level));
        settings_used++;
      end
      req.rate = row.rate;
      req.phase = row.phase;
      req.restart = row.restart;
      req.last = row.last;
      send_beat(req, row.pinned, row.pin_sample);
    end

    for (int k = 0; k < N_SETTINGS; k++) begin
      mode_sel = (k < 4) ? 2'(k) : 2'($urandom_range(3));
      case (k)
        0: begin
          level_sel = LVL_MIN;
          rate_sel = RATE_MAX;
          inv_sel = INV_MAX;
          start_sel = 32'hffff_ffff;
        end
        1: begin
          level_sel = LVL_MAX;
          rate_sel = RATE_MIN;
          inv_sel = 37'd1;
          start_sel = 32'd0;
        end
        2: begin
          level_sel = 16'sd0;
          rate_sel = 25'sd0;
          inv_sel = INV_RESET;
          start_sel = 32'h8000_0000;
        end
        default: begin
          case ($urandom_range(3))
            0: level_sel = $urandom_range(1) ? LVL_MAX : LVL_MIN;
            default: level_sel = 16'($urandom);
          endcase
          case ($urandom_range(4))
            0: rate_sel = RATE_MAX;
            1: rate_sel = RATE_MIN;
            2: rate_sel = 25'($urandom);
            default: begin
              rate_sel = 25'($urandom_range(1, 5_000_000));
              if ($urandom_range(1) != 0) rate_sel = -rate_sel;
            end
          endcase
          case ($urandom_range(3))
            0: inv_sel = $urandom_range(1) ? INV_MAX : 37'd1;
            1: inv_sel = {5'($urandom), 32'($urandom)};
            default: inv_sel = 37'($urandom_range(10_000_000, 50_000_000));
          endcase
          case ($urandom_range(3))
            0: start_sel = 32'd0;
            1: start_sel = 32'hffff_ffff;
            default: start_sel = $urandom;
          endcase
        end
      endcase

      settle();
      reg_write(CFG_WAVE_SHAPE, 37'(k % 8));
      reg_write(CFG_DRIVE_MODE, 37'(mode_sel));
      reg_write(CFG_PEAK_LEVEL, 37'(level_sel));
      reg_write(CFG_CONST_RATE_HZ, 37'(rate_sel));
      reg_write(CFG_INV_SAMPLE_RATE, inv_sel);
      reg_write(CFG_START_PHASE, 37'(start_sel));
      settings_used++;

      ramp = $urandom;
      ramp_step = $urandom_range(1, 32'h3fff_ffff);
      tx_calm = (k == 5 || k == 9);
      rx_calm = (k == 9);
      // hold the output off while beats keep coming in
      if (k == 5) hold_ask = ~hold_ask;

      for (int j = 0; j < BEATS_PER_SETTING; j++) begin
        if (k == 12 && j == BEATS_PER_SETTING / 2) begin
          in_if.valid <= 1'b0;
          while (expected_q.size() != 0) begin
            @(posedge clk);
          end
        end
        case ($urandom_range(3))
          0: req.rate = 25'($urandom);
          1: req.rate = 25'($urandom_range(1, 5_000_000));
          2: req.rate = -25'($urandom_range(1, 5_000_000));
          default: req.rate = $urandom_range(1) ? RATE_MAX : RATE_MIN;
        endcase
        if ($urandom_range(4) == 0) begin
          req.phase = $urandom;
        end else begin
          req.phase = ramp;
          ramp = ramp + ramp_step;
        end
        req.restart = ($urandom_range(15) == 0);
        req.last = ($urandom_range(7) == 0);
        send_beat(req, 1'b0, 16'sd0);
      end
      tx_calm = 1'b0;
      rx_calm = 1'b0;
    end

    settle();
    $display("run covered %0d input beats and %0d checked samples over %0d register settings",
             beats_sent, beats_checked, settings_used);
    $display("with all eight shapes, four drive modes, restarts, a long output stall and a drain");
    if (errors == 0) begin
      $display("multi_waveform_oscillator_tb OK");
    end else begin
      $display("multi_waveform_oscillator_tb NOT OK");
    end
    $finish;
  end

endmodule

[multi_waveform_oscillator.f]
src/mwosc_pkg.sv
src/mwosc_in_if.sv
src/mwosc_out_if.sv
src/mwosc_front.sv
src/mwosc_queue.sv
src/mwosc_back.sv
src/multi_waveform_oscillator.sv
tb/sv/multi_waveform_oscillator_tb.sv
